[sv/gvd_pkg.sv]
package gvd_pkg;

  localparam int MAX_CELLS_PER_AXIS = 32;
  localparam int NUM_AXES   = 3;
  localparam int COORD_W    = 5;
  localparam int ADDR_W     = NUM_AXES * COORD_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int COMP_W     = 32;
  localparam int INV_W      = 32;
  localparam int PROD_W     = COMP_W + INV_W;
  localparam int DIV_W      = 48;
  localparam int GRID_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int RES_DEPTH  = 8;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int CREDIT_W   = $clog2(RES_DEPTH + 1);

  localparam logic [GRID_W-1:0] GRID_SIZE_RST = GRID_W'(32);
  localparam logic [INV_W-1:0]  INV_RST       = INV_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE     = 3'd0,
    REG_PERIODIC_MODE = 3'd1,
    REG_INV_TWO_DX1   = 3'd2,
    REG_INV_TWO_DX2   = 3'd3,
    REG_INV_TWO_DX3   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CALC = 1'b1
  } op_t;

  typedef enum logic {
    SQ_FETCH,
    SQ_DOWN
  } seq_state_t;

  // One queued command. For a compute, ok low means the answer is a plain
  // invalid result and the neighbour reads are don't-care.
  typedef struct packed {
    op_t                                op;
    logic                               ok;
    logic [ADDR_W-1:0]                  addr;
    logic [NUM_AXES-1:0][ADDR_W-1:0]    up_addr;
    logic [NUM_AXES-1:0][ADDR_W-1:0]    dn_addr;
    logic [NUM_AXES-1:0][COMP_W-1:0]    data;
  } cmd_t;

  typedef struct packed {
    logic             ok;
    logic [DIV_W-1:0] div;
  } res_t;

endpackage

[sv/gvd_front.sv]
module gvd_front
  import gvd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_func,
  input  logic [COORD_W-1:0]   in_coord_i,
  input  logic [COORD_W-1:0]   in_coord_j,
  input  logic [COORD_W-1:0]   in_coord_k,
  input  logic signed [COMP_W-1:0] in_comp_one,
  input  logic signed [COMP_W-1:0] in_comp_two,
  input  logic signed [COMP_W-1:0] in_comp_three,
  input  logic [GRID_W-1:0]    grid_size,
  input  logic                 periodic_mode,
  input  logic                 cmd_pop,
  output cmd_t                 cmd,
  output logic                 cmd_empty
);

  // Neighbour one step ahead, wrapping to zero at the grid edge.
  function automatic logic [COORD_W-1:0] nb_up(input logic [COORD_W-1:0] c,
                                               input logic [GRID_W-1:0] n);
    logic [GRID_W-1:0] c1;
    c1 = GRID_W'(c) + GRID_W'(1);
    return (c1 == n) ? '0 : c1[COORD_W-1:0];
  endfunction

  // Neighbour one step behind, wrapping to n-1 at the grid edge.
  function automatic logic [COORD_W-1:0] nb_down(input logic [COORD_W-1:0] c,
                                                 input logic [GRID_W-1:0] n);
    logic [GRID_W-1:0] nm1;
    nm1 = n - GRID_W'(1);
    return (c == '0) ? nm1[COORD_W-1:0] : c - COORD_W'(1);
  endfunction

  logic [GRID_W-1:0]     n_eff;
  logic                  in_grid;
  logic                  on_edge;
  logic                  keep;
  logic                  enq;
  logic                  deq;
  logic [COORD_W-1:0]    ui, uj, uk, di, dj, dk;
  cmd_t                  cmd_new;

  cmd_t                  q_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CMD_PTR_W:0]    cnt_r;

  always_comb begin
    n_eff = (grid_size > GRID_W'(MAX_CELLS_PER_AXIS)) ? GRID_W'(MAX_CELLS_PER_AXIS)
                                                      : grid_size;
    in_grid = (GRID_W'(in_coord_i) < n_eff) && (GRID_W'(in_coord_j) < n_eff) &&
              (GRID_W'(in_coord_k) < n_eff);
    on_edge = (in_coord_i == '0) || (in_coord_j == '0) || (in_coord_k == '0) ||
              (GRID_W'(in_coord_i) + GRID_W'(1) >= n_eff) ||
              (GRID_W'(in_coord_j) + GRID_W'(1) >= n_eff) ||
              (GRID_W'(in_coord_k) + GRID_W'(1) >= n_eff);
    ui = nb_up(in_coord_i, n_eff);
    uj = nb_up(in_coord_j, n_eff);
    uk = nb_up(in_coord_k, n_eff);
    di = nb_down(in_coord_i, n_eff);
    dj = nb_down(in_coord_j, n_eff);
    dk = nb_down(in_coord_k, n_eff);

    cmd_new.op         = op_t'(in_func);
    cmd_new.ok         = in_grid && (periodic_mode || !on_edge);
    cmd_new.addr       = {in_coord_i, in_coord_j, in_coord_k};
    cmd_new.up_addr[0] = {ui, in_coord_j, in_coord_k};
    cmd_new.up_addr[1] = {in_coord_i, uj, in_coord_k};
    cmd_new.up_addr[2] = {in_coord_i, in_coord_j, uk};
    cmd_new.dn_addr[0] = {di, in_coord_j, in_coord_k};
    cmd_new.dn_addr[1] = {in_coord_i, dj, in_coord_k};
    cmd_new.dn_addr[2] = {in_coord_i, in_coord_j, dk};
    cmd_new.data[0]    = in_comp_one;
    cmd_new.data[1]    = in_comp_two;
    cmd_new.data[2]    = in_comp_three;

    // Loads that fall outside the grid are taken and dropped here.
    keep = (op_t'(in_func) == OP_CALC) || in_grid;
    full = (cnt_r == (CMD_PTR_W+1)'(CMD_DEPTH));
    enq  = push && !full && keep;
    cmd_empty = (cnt_r == '0);
    deq  = cmd_pop && !cmd_empty;
    cmd  = q_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) wr_ptr_r <= wr_ptr_r + CMD_PTR_W'(1);
      if (deq) rd_ptr_r <= rd_ptr_r + CMD_PTR_W'(1);
      cnt_r <= cnt_r + (CMD_PTR_W+1)'(enq) - (CMD_PTR_W+1)'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) q_r[wr_ptr_r] <= cmd_new;
  end

endmodule

[sv/gvd_back.sv]
module gvd_back
  import gvd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  input  logic [NUM_AXES-1:0][INV_W-1:0] inv,
  input  logic                          res_taken,
  output logic                          res_push,
  output res_t                          res
);

  localparam int SH_W  = PROD_W + 1 - 16;
  localparam int TRM_W = SH_W + 1;
  localparam int SUM_W = DIV_W + 4;

  seq_state_t state_r, state_nxt;
  logic [CREDIT_W-1:0] credits_r;
  logic start_calc, do_load, rd_en;
  logic [ADDR_W-1:0] rd_addr [NUM_AXES];

  logic [NUM_AXES-1:0][ADDR_W-1:0] cur_dn_r;
  logic cur_ok_r;
  logic [COMP_W-1:0] rd_r [NUM_AXES];
  logic [COMP_W-1:0] up_r [NUM_AXES];
  logic dat_v_r, dat_ok_r;

  logic signed [COMP_W:0] diff [NUM_AXES];
  logic [COMP_W:0]   neg_diff [NUM_AXES];
  logic [COMP_W-1:0] mag_r [NUM_AXES];
  logic [NUM_AXES-1:0] neg_r, neg2_r;
  logic s1_v_r, s1_ok_r;
  logic [PROD_W-1:0] prod_r [NUM_AXES];
  logic s2_v_r, s2_ok_r;

  logic [PROD_W:0] rnd [NUM_AXES];
  logic [SH_W-1:0] sh [NUM_AXES];
  logic signed [TRM_W-1:0] term [NUM_AXES];
  logic signed [SUM_W-1:0] sum;
  logic [DIV_W-1:0] sat;

  always_comb begin
    start_calc = (state_r == SQ_FETCH) && !cmd_empty && (cmd.op == OP_CALC) &&
                 (credits_r != '0);
    do_load    = (state_r == SQ_FETCH) && !cmd_empty && (cmd.op == OP_LOAD);
    cmd_pop    = start_calc || do_load;
    rd_en      = start_calc || (state_r == SQ_DOWN);
    for (int a = 0; a < NUM_AXES; a++) begin
      rd_addr[a] = (state_r == SQ_DOWN) ? cur_dn_r[a] : cmd.up_addr[a];
    end
    state_nxt = state_r;
    case (state_r)
      SQ_FETCH: if (start_calc) state_nxt = SQ_DOWN;
      SQ_DOWN:  state_nxt = SQ_FETCH;
      default:  state_nxt = SQ_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SQ_FETCH;
      credits_r <= CREDIT_W'(RES_DEPTH);
      dat_v_r   <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      credits_r <= credits_r - CREDIT_W'(start_calc) + CREDIT_W'(res_taken);
      dat_v_r   <= (state_r == SQ_DOWN);
      s1_v_r    <= dat_v_r;
      s2_v_r    <= s1_v_r;
    end
  end

  // Component stores, one port each: a load writes, a compute reads.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_store
    logic [COMP_W-1:0] mem_r [STORE_DEPTH];
    always_ff @(posedge clk) begin
      if (do_load) begin
        mem_r[cmd.addr] <= cmd.data[a];
      end else if (rd_en) begin
        rd_r[a] <= mem_r[rd_addr[a]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_calc) begin
      cur_dn_r <= cmd.dn_addr;
      cur_ok_r <= cmd.ok;
    end
    if (state_r == SQ_DOWN) begin
      up_r     <= rd_r;
      dat_ok_r <= cur_ok_r;
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a]     = $signed({up_r[a][COMP_W-1], up_r[a]}) -
                    $signed({rd_r[a][COMP_W-1], rd_r[a]});
      neg_diff[a] = -diff[a];
    end
  end

  // The difference magnitude never exceeds 2^32-1, so it fits 32 bits.
  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      neg_r[a]  <= diff[a][COMP_W];
      mag_r[a]  <= diff[a][COMP_W] ? neg_diff[a][COMP_W-1:0] : diff[a][COMP_W-1:0];
      prod_r[a] <= PROD_W'(mag_r[a]) * PROD_W'(inv[a]);
    end
    neg2_r  <= neg_r;
    s1_ok_r <= dat_ok_r;
    s2_ok_r <= s1_ok_r;
  end

  // Floor of the signed product over 2^16, summed and clamped to 48 bits.
  always_comb begin
    sum = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      rnd[a]  = neg2_r[a] ? ({1'b0, prod_r[a]} + (PROD_W+1)'(16'hFFFF))
                          : {1'b0, prod_r[a]};
      sh[a]   = rnd[a][PROD_W:16];
      term[a] = neg2_r[a] ? -$signed({1'b0, sh[a]}) : $signed({1'b0, sh[a]});
      sum     = sum + SUM_W'(term[a]);
    end
    if ((&sum[SUM_W-1:DIV_W-1]) || !(|sum[SUM_W-1:DIV_W-1])) begin
      sat = sum[DIV_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(DIV_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DIV_W-1){1'b1}}};
    end
    res_push = s2_v_r;
    res.ok   = s2_ok_r;
    res.div  = s2_ok_r ? sat : '0;
  end

endmodule

[sv/gvd_res_queue.sv]
module gvd_res_queue
  import gvd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_push,
  input  res_t res_in,
  input  logic res_pop,
  output res_t res_out,
  output logic res_empty,
  output logic res_full
);

  res_t                 q_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [RES_PTR_W:0]   cnt_r;
  logic                 deq;

  always_comb begin
    res_empty = (cnt_r == '0);
    res_full  = (cnt_r == (RES_PTR_W+1)'(RES_DEPTH));
    deq       = res_pop && !res_empty;
    res_out   = q_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (res_push) wr_ptr_r <= wr_ptr_r + RES_PTR_W'(1);
      if (deq) rd_ptr_r <= rd_ptr_r + RES_PTR_W'(1);
      cnt_r <= cnt_r + (RES_PTR_W+1)'(res_push) - (RES_PTR_W+1)'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) q_r[wr_ptr_r] <= res_in;
  end

endmodule

[sv/grid_vector_divergence_core.sv]
// Central-difference divergence of a 3-component vector field on a cubic grid.
// Input beats arrive on a queue-style port (push/full). A load beat writes the
// three Q16.16 components of one cell; a compute beat asks for the divergence
// at a cell and produces exactly one result beat (empty/pop), loads produce
// none. Results leave in the order their compute beats came in.
// A compute holds the back end for the two reads each single-port component
// store needs (neighbour ahead, then neighbour behind); a load needs only its
// write. When nothing is backed up, a compute passes through the command queue,
// the store reads, the magnitude and product registers and the result queue.
// A four-entry command queue sits between the front end and the back end, so
// input beats keep being accepted while the back end is busy or the output is
// stalled. The back end holds credits for the eight-entry result queue and
// stops issuing computes when they run out; full rises once the command queue
// fills. Configuration writes go straight to the registers and are meant to
// happen only when the block is idle.
// Reset (synchronous, active low) empties both queues and restores the
// registers to grid size 32, interior mode and unit reciprocals. The stores
// are not cleared; a cell must be loaded before it is read.
module grid_vector_divergence_core
  import gvd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      push,
  output logic                      full,
  input  logic                      in_func,
  input  logic [COORD_W-1:0]        in_coord_i,
  input  logic [COORD_W-1:0]        in_coord_j,
  input  logic [COORD_W-1:0]        in_coord_k,
  input  logic signed [COMP_W-1:0]  in_comp_one,
  input  logic signed [COMP_W-1:0]  in_comp_two,
  input  logic signed [COMP_W-1:0]  in_comp_three,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [DIV_W-1:0]   out_divergence,
  output logic                      out_valid_res
);

  // Configuration registers.
  logic [GRID_W-1:0]                grid_size_r;
  logic                             periodic_mode_r;
  logic [NUM_AXES-1:0][INV_W-1:0]   inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r     <= GRID_SIZE_RST;
      periodic_mode_r <= 1'b0;
      inv_r           <= {NUM_AXES{INV_RST}};
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_SIZE:     grid_size_r     <= cfg_data[GRID_W-1:0];
        REG_PERIODIC_MODE: periodic_mode_r <= cfg_data[0];
        REG_INV_TWO_DX1:   inv_r[0]        <= cfg_data[INV_W-1:0];
        REG_INV_TWO_DX2:   inv_r[1]        <= cfg_data[INV_W-1:0];
        REG_INV_TWO_DX3:   inv_r[2]        <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  logic res_push;
  res_t res_new;
  res_t res_head;
  logic res_full;
  logic res_taken;

  // The front end classifies each beat and queues it with its neighbour
  // addresses already worked out.
  gvd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_func       (in_func),
    .in_coord_i    (in_coord_i),
    .in_coord_j    (in_coord_j),
    .in_coord_k    (in_coord_k),
    .in_comp_one   (in_comp_one),
    .in_comp_two   (in_comp_two),
    .in_comp_three (in_comp_three),
    .grid_size     (grid_size_r),
    .periodic_mode (periodic_mode_r),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd),
    .cmd_empty     (cmd_empty)
  );

  // The back end owns the stores and the arithmetic pipeline.
  gvd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .inv       (inv_r),
    .res_taken (res_taken),
    .res_push  (res_push),
    .res       (res_new)
  );

  gvd_res_queue u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_in    (res_new),
    .res_pop   (pop),
    .res_out   (res_head),
    .res_empty (empty),
    .res_full  (res_full)
  );

  assign res_taken      = pop && !empty;
  assign out_divergence = res_head.div;
  assign out_valid_res  = res_head.ok;

`ifndef NO_ASSERTIONS
  // Credits must keep the result queue from ever overflowing.
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full result queue");

  // The back end only takes commands that are really there.
  a_cmd_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty command queue");

  // An invalid result always carries a zero divergence.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_valid_res) |-> (out_divergence == '0))
    else $error("invalid result with nonzero divergence");
`endif

endmodule
